@@ sv/mrpm_pkg.sv @@
// shared types, constants and crc function for the modbus rtu poll master
package mrpm_pkg;

    localparam int SLAVE_SLOTS_DEF = 8;

    localparam logic [15:0] POLL_INTERVAL_RST = 16'd100;
    localparam logic [2:0]  MAX_ATTEMPTS_RST  = 3'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_PASS  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register indexes
    localparam logic REG_POLL_INTERVAL = 1'b0;
    localparam logic REG_MAX_ATTEMPTS  = 1'b1;

    // frame byte positions
    localparam logic [2:0] BYTE_STATION = 3'd0;
    localparam logic [2:0] BYTE_FUNC    = 3'd1;
    localparam logic [2:0] BYTE_REG_HI  = 3'd2;
    localparam logic [2:0] BYTE_REG_LO  = 3'd3;
    localparam logic [2:0] BYTE_QTY_HI  = 3'd4;
    localparam logic [2:0] BYTE_QTY_LO  = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO  = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI  = 3'd7;

    localparam int ENTRY_W = 48;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  entry_slot;
        logic        entry_enable;
        logic [7:0]  entry_station;
        logic [7:0]  entry_function;
        logic [15:0] entry_register;
        logic [15:0] entry_quantity;
        logic        response_done;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic [2:0] polled_slot;
    } frame_item_t;

    typedef struct packed {
        logic accept;
        logic search_step;
        logic check;
        logic load_frame;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pass;
        logic adv_needed;
        logic search_done;
        logic check_send;
        logic out_free;
        logic last_byte;
    } dp_status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/mrpm_ram.sv @@
// generic single-port-write ram with registered read
module mrpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/mrpm_ctrl.sv @@
// sequencing state machine of the poll master
module mrpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mrpm_pkg::dp_status_t status,
    output mrpm_pkg::ctrl_cmd_t  ctrl
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_READ   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctrl.accept = 1'b1;
                    if (status.is_pass)
                    begin
                        state_next = status.adv_needed ? ST_SEARCH : ST_CHECK;
                    end
                end
            end
            ST_SEARCH:
            begin
                ctrl.search_step = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ctrl.check = 1'b1;
                state_next = status.check_send ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                ctrl.load_frame = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    ctrl.emit = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/mrpm_dp.sv @@
// slave table, polling state, crc and frame output register
module mrpm_dp #(
    parameter int SLAVE_SLOTS = mrpm_pkg::SLAVE_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrpm_pkg::cmd_item_t   cmd_data,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output mrpm_pkg::frame_item_t frame_data,
    input  logic [15:0]           poll_interval,
    input  logic [2:0]            max_attempts,
    input  mrpm_pkg::ctrl_cmd_t   ctrl,
    output mrpm_pkg::dp_status_t  status
);

    localparam int SLOT_W = $clog2(SLAVE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLAVE_SLOTS - 1);

    logic [SLAVE_SLOTS-1:0] en_reg;
    logic [SLOT_W-1:0]      current_slot_reg;
    logic [3:0]             attempt_reg;
    logic [15:0]            interval_reg;
    logic                   adv_pending_reg;
    logic                   target_valid_reg;
    logic [SLOT_W-1:0]      scan_idx_reg;
    logic [SLOT_W-1:0]      scan_cnt_reg;
    logic [2:0]             byte_idx_reg;
    logic                   out_valid_reg;

    logic [mrpm_pkg::ENTRY_W-1:0] frame_reg;
    logic [15:0]                  crc_reg;
    mrpm_pkg::frame_item_t        out_data_reg;

    logic [6:0]                   slot_ext;
    logic [SLOT_W-1:0]            wr_addr;
    logic                         wr_in_range;
    logic                         table_wr;
    logic [mrpm_pkg::ENTRY_W-1:0] ram_rd_data;
    logic [SLOT_W-1:0]            start_idx;
    logic [SLOT_W-1:0]            scan_idx_inc;
    logic                         scan_hit;
    logic [3:0]                   attempt_inc;
    logic                         over_max;
    logic                         interval_zero;
    logic                         out_free;
    logic [7:0]                   cur_byte;
    logic [6:0]                   cur_slot_ext;

    assign slot_ext    = {4'b0000, cmd_data.entry_slot};
    assign wr_addr     = slot_ext[SLOT_W-1:0];
    assign wr_in_range = slot_ext < 7'(SLAVE_SLOTS);
    assign table_wr    = ctrl.accept && (cmd_data.command == mrpm_pkg::CMD_WRITE) && wr_in_range;

    assign start_idx    = (current_slot_reg == LAST_SLOT) ? '0 : current_slot_reg + 1'b1;
    assign scan_idx_inc = (scan_idx_reg == LAST_SLOT) ? '0 : scan_idx_reg + 1'b1;
    assign scan_hit     = en_reg[scan_idx_reg];

    assign attempt_inc   = attempt_reg + 4'd1;
    assign over_max      = attempt_inc > {1'b0, max_attempts};
    assign interval_zero = (interval_reg == 16'd0);
    assign out_free      = !out_valid_reg || !frame_stall;
    assign cur_slot_ext  = 7'(current_slot_reg);

    mrpm_ram #(
        .WIDTH(mrpm_pkg::ENTRY_W),
        .DEPTH(SLAVE_SLOTS)
    ) u_table (
        .clk    (clk),
        .wr_en  (table_wr),
        .wr_addr(wr_addr),
        .wr_data({cmd_data.entry_station, cmd_data.entry_function,
                  cmd_data.entry_register, cmd_data.entry_quantity}),
        .rd_en  (ctrl.check),
        .rd_addr(current_slot_reg),
        .rd_data(ram_rd_data)
    );

    always_comb
    begin
        case (byte_idx_reg)
            mrpm_pkg::BYTE_STATION: cur_byte = frame_reg[47:40];
            mrpm_pkg::BYTE_FUNC:    cur_byte = frame_reg[39:32];
            mrpm_pkg::BYTE_REG_HI:  cur_byte = frame_reg[31:24];
            mrpm_pkg::BYTE_REG_LO:  cur_byte = frame_reg[23:16];
            mrpm_pkg::BYTE_QTY_HI:  cur_byte = frame_reg[15:8];
            mrpm_pkg::BYTE_QTY_LO:  cur_byte = frame_reg[7:0];
            mrpm_pkg::BYTE_CRC_LO:  cur_byte = crc_reg[7:0];
            default:                cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        status.is_pass     = (cmd_data.command == mrpm_pkg::CMD_PASS);
        status.adv_needed  = adv_pending_reg || cmd_data.response_done;
        status.search_done = scan_hit || (scan_cnt_reg == LAST_SLOT);
        status.check_send  = target_valid_reg && interval_zero && !over_max;
        status.out_free    = out_free;
        status.last_byte   = (byte_idx_reg == mrpm_pkg::BYTE_CRC_HI);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg           <= '0;
            current_slot_reg <= '0;
            attempt_reg      <= '0;
            interval_reg     <= '0;
            adv_pending_reg  <= 1'b1;
            target_valid_reg <= 1'b0;
            scan_idx_reg     <= '0;
            scan_cnt_reg     <= '0;
            byte_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (table_wr)
            begin
                en_reg[wr_addr] <= cmd_data.entry_enable;
            end

            if (ctrl.accept && (cmd_data.command == mrpm_pkg::CMD_TICK) && !interval_zero)
            begin
                interval_reg <= interval_reg - 16'd1;
            end

            if (ctrl.accept && status.is_pass && status.adv_needed)
            begin
                adv_pending_reg  <= 1'b0;
                attempt_reg      <= '0;
                target_valid_reg <= 1'b0;
                scan_idx_reg     <= start_idx;
                scan_cnt_reg     <= '0;
            end

            if (ctrl.search_step)
            begin
                if (scan_hit)
                begin
                    current_slot_reg <= scan_idx_reg;
                    target_valid_reg <= 1'b1;
                end
                scan_idx_reg <= scan_idx_inc;
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end

            if (ctrl.check)
            begin
                if (!target_valid_reg)
                begin
                    adv_pending_reg <= 1'b1;
                end
                else if (interval_zero)
                begin
                    if (over_max)
                    begin
                        attempt_reg     <= '0;
                        adv_pending_reg <= 1'b1;
                    end
                    else
                    begin
                        attempt_reg  <= attempt_inc;
                        interval_reg <= poll_interval;
                    end
                end
            end

            if (ctrl.load_frame)
            begin
                byte_idx_reg <= '0;
            end
            else if (ctrl.emit)
            begin
                byte_idx_reg <= byte_idx_reg + 3'd1;
            end

            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!frame_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // frame payload and crc
    always_ff @(posedge clk)
    begin
        if (ctrl.load_frame)
        begin
            frame_reg <= ram_rd_data;
            crc_reg   <= mrpm_pkg::CRC_INIT;
        end
        else if (ctrl.emit && (byte_idx_reg < mrpm_pkg::BYTE_CRC_LO))
        begin
            crc_reg <= mrpm_pkg::crc_byte(crc_reg, cur_byte);
        end

        if (ctrl.emit)
        begin
            out_data_reg.frame_byte  <= cur_byte;
            out_data_reg.frame_last  <= (byte_idx_reg == mrpm_pkg::BYTE_CRC_HI);
            out_data_reg.polled_slot <= cur_slot_ext[2:0];
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_data_reg;

endmodule

@@ sv/modbus_rtu_poll_master.sv @@
// top level of the modbus rtu poll master with apb register port
// sequence: table write, tick and idle commands finish on acceptance; a pass
//   runs a round-robin search over up to SLAVE_SLOTS slots when an advance is due, an
//   attempt check, a table ram read and the send of 8 frame bytes, which frame_stall can hold
// commands: one transfer at a time, none taken during a pass; the search checks
//   one slot per cycle and bytes go out one per cycle unless frame_stall holds them
// reset: asynchronous, active low; all slots disabled, advance pending set,
//   poll_interval 100, max_attempts 3; no clearing pass, polls only slots found enabled
module modbus_rtu_poll_master #(
    parameter int SLAVE_SLOTS = mrpm_pkg::SLAVE_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // command channel
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  mrpm_pkg::cmd_item_t   cmd_data,

    // request frame channel, one byte per transfer
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output mrpm_pkg::frame_item_t frame_data,

    // apb register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] poll_interval_reg;
    logic [2:0]  max_attempts_reg;
    logic        reg_index;
    logic        reg_wr;

    mrpm_pkg::ctrl_cmd_t  ctrl;
    mrpm_pkg::dp_status_t status;

    // registers sit at byte addresses 0 and 4
    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign reg_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= mrpm_pkg::POLL_INTERVAL_RST;
            max_attempts_reg  <= mrpm_pkg::MAX_ATTEMPTS_RST;
        end
        else if (reg_wr)
        begin
            unique case (reg_index)
                mrpm_pkg::REG_POLL_INTERVAL: poll_interval_reg <= pwdata[15:0];
                mrpm_pkg::REG_MAX_ATTEMPTS:  max_attempts_reg  <= pwdata[2:0];
                default:                     poll_interval_reg <= poll_interval_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_index)
            mrpm_pkg::REG_POLL_INTERVAL: prdata = {16'h0000, poll_interval_reg};
            mrpm_pkg::REG_MAX_ATTEMPTS:  prdata = {29'h0, max_attempts_reg};
            default:                     prdata = 32'h0;
        endcase
    end

    // sequencer: idle, slot search, attempt check, table read, byte send
    mrpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    // table, polling state, crc and output register
    mrpm_dp #(
        .SLAVE_SLOTS(SLAVE_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_data     (cmd_data),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_data   (frame_data),
        .poll_interval(poll_interval_reg),
        .max_attempts (max_attempts_reg),
        .ctrl         (ctrl),
        .status       (status)
    );

endmodule
